[design/bracket_loop_numbering_top_macros.svh]
// Assertion macros used by the file that checks the loop numbering block.
`ifndef BRACKET_LOOP_NUMBERING_TOP_MACROS_SVH
`define BRACKET_LOOP_NUMBERING_TOP_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define BLN_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("loop numbering check failed");

// Next-cycle implication, held off while reset is asserted.
`define BLN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("loop numbering check failed");

`endif

[design/bln_pkg.sv]
package bln_pkg;

    // Fixed field widths.
    localparam int PARTNER_W = 11;
    localparam int LOOP_W    = 10;

    // Saturation limits of the position and loop counters.
    localparam logic [PARTNER_W-1:0] POS_MAX  = {PARTNER_W{1'b1}};
    localparam logic [LOOP_W-1:0]    LOOP_MAX = {LOOP_W{1'b1}};

    // Default number of stack entries.
    localparam int STACK_DEPTH_DEF = 512;

    // One result item.
    typedef struct packed {
        logic [LOOP_W-1:0] loop_number;
        logic [LOOP_W-1:0] loops_total;
        logic              unbalanced;
        logic              last_out;
    } t_result;

endpackage

[design/bln_stack_mem.sv]
module bln_stack_mem #(
    parameter int STACK_DEPTH = bln_pkg::STACK_DEPTH_DEF,
    parameter int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
    input  logic                      i_clk,
    input  logic                      i_wr_en,
    input  logic [ADDR_W-1:0]         i_wr_addr,
    input  logic [bln_pkg::LOOP_W-1:0] i_wr_data,
    input  logic [ADDR_W-1:0]         i_rd_addr,
    output logic [bln_pkg::LOOP_W-1:0] o_rd_data
);
    import bln_pkg::*;

    logic [LOOP_W-1:0] r_stack [STACK_DEPTH];
    logic [LOOP_W-1:0] r_rd_data;

    // Single write port, registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_stack[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_stack[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[design/bln_step.sv]
module bln_step #(
    parameter int STACK_DEPTH = bln_pkg::STACK_DEPTH_DEF,
    parameter int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic [bln_pkg::PARTNER_W-1:0] i_partner,
    input  logic                         i_last_base,
    input  logic [bln_pkg::LOOP_W-1:0]    i_rd_data,
    output logic [ADDR_W-1:0]            o_rd_addr,
    output logic                         o_wr_en,
    output logic [ADDR_W-1:0]            o_wr_addr,
    output logic [bln_pkg::LOOP_W-1:0]    o_wr_data,
    output bln_pkg::t_result             o_result
);
    import bln_pkg::*;

    localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
    localparam logic [DEPTH_W-1:0] DepthFull = DEPTH_W'(STACK_DEPTH);

    logic [PARTNER_W-1:0] r_pos,   n_pos;
    logic [LOOP_W-1:0]    r_loops, n_loops;
    logic [LOOP_W-1:0]    r_cur,   n_cur;
    logic                 r_cur_from_mem, n_cur_from_mem;
    logic [DEPTH_W-1:0]   r_depth, n_depth;
    logic                 r_err,   n_err;

    logic              is_open;
    logic              is_close;
    logic              push_ok;
    logic [LOOP_W-1:0] cur_eff;
    logic [LOOP_W-1:0] loops_new;
    logic [LOOP_W-1:0] cur_mid;
    logic              err_mid;
    logic [DEPTH_W-1:0] depth_pop;

    // The loop below the top is read every cycle; after a pop it becomes current.
    assign o_rd_addr = ADDR_W'(r_depth - DEPTH_W'(2));
    assign cur_eff   = r_cur_from_mem ? i_rd_data : r_cur;

    // Classify the position and form the result.
    assign is_open   = (i_partner != '0) && (r_pos < i_partner);
    assign is_close  = (i_partner != '0) && (r_pos > i_partner);
    assign loops_new = (is_open && (r_loops != LOOP_MAX)) ? r_loops + 1'b1 : r_loops;
    assign cur_mid   = is_open ? loops_new : cur_eff;
    assign push_ok   = is_open && (r_depth < DepthFull);
    assign err_mid   = r_err | (is_open & ~push_ok);
    assign depth_pop = r_depth - 1'b1;

    // Push the new loop number at the current depth.
    assign o_wr_en   = i_accept & push_ok;
    assign o_wr_addr = r_depth[ADDR_W-1:0];
    assign o_wr_data = loops_new;

    // Next state of the counters and the current loop.
    always_comb begin
        n_pos          = r_pos;
        n_loops        = r_loops;
        n_cur          = cur_eff;
        n_cur_from_mem = 1'b0;
        n_depth        = r_depth;
        n_err          = r_err;

        o_result.loop_number = cur_mid;
        o_result.loops_total = loops_new;
        o_result.unbalanced  = err_mid;
        o_result.last_out    = i_last_base;

        if (is_close) begin
            if (r_depth == '0) begin
                o_result.unbalanced = 1'b1;
            end
        end

        if (i_accept) begin
            n_pos   = (r_pos != POS_MAX) ? r_pos + 1'b1 : r_pos;
            n_loops = loops_new;
            n_cur   = cur_mid;
            n_depth = push_ok ? r_depth + 1'b1 : r_depth;
            n_err   = err_mid;
            if (is_close) begin
                if (r_depth == '0) begin
                    n_err = 1'b1;
                    n_cur = '0;
                end else begin
                    n_depth = depth_pop;
                    if (depth_pop != '0) begin
                        n_cur_from_mem = 1'b1;
                    end else begin
                        n_cur = '0;
                    end
                end
            end
            if (i_last_base) begin
                n_pos          = PARTNER_W'(1);
                n_loops        = '0;
                n_cur          = '0;
                n_cur_from_mem = 1'b0;
                n_depth        = '0;
                n_err          = 1'b0;
            end
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos          <= PARTNER_W'(1);
            r_loops        <= '0;
            r_cur          <= '0;
            r_cur_from_mem <= 1'b0;
            r_depth        <= '0;
            r_err          <= 1'b0;
        end else begin
            r_pos          <= n_pos;
            r_loops        <= n_loops;
            r_cur          <= n_cur;
            r_cur_from_mem <= n_cur_from_mem;
            r_depth        <= n_depth;
            r_err          <= n_err;
        end
    end

endmodule

[design/bracket_loop_numbering_top.sv]
// Latency: a result is valid in the cycle after its item's transfer.
// Throughput: one item per cycle while not stalled; the stack memory's registered read of
// the enclosing loop is forwarded straight into the next item after a close.
// Reset (synchronous, active low) clears the counters, the depth, the error flag
// and the output valid; the stack memory itself is not cleared.
module bracket_loop_numbering_top #(
    parameter int STACK_DEPTH = bln_pkg::STACK_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [bln_pkg::PARTNER_W-1:0] i_partner,
    input  logic                         i_last_base,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [bln_pkg::LOOP_W-1:0]    o_loop_number,
    output logic [bln_pkg::LOOP_W-1:0]    o_loops_total,
    output logic                         o_unbalanced,
    output logic                         o_last_out
);
    import bln_pkg::*;

`include "bracket_loop_numbering_top_macros.svh"

    localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    logic              in_accept;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic              wr_en;
    logic [LOOP_W-1:0] wr_data;
    logic [LOOP_W-1:0] rd_data;
    t_result           step_result;
    t_result           r_out;
    logic              r_out_valid;

    // Input transfer happens whenever the output register is free or drains.
    assign o_stall   = r_out_valid & i_stall;
    assign in_accept = i_valid & ~o_stall;

    bln_stack_mem #(
        .STACK_DEPTH (STACK_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_stack_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    bln_step #(
        .STACK_DEPTH (STACK_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_partner   (i_partner),
        .i_last_base (i_last_base),
        .i_rd_data   (rd_data),
        .o_rd_addr   (rd_addr),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_result    (step_result)
    );

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= step_result;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_loop_number = r_out.loop_number;
    assign o_loops_total = r_out.loops_total;
    assign o_unbalanced  = r_out.unbalanced;
    assign o_last_out    = r_out.last_out;

    // A loop number never exceeds the count of loops opened.
    `BLN_ASSERT_IMPL(a_loop_in_range, i_clk, i_rst_n, o_valid, o_loop_number <= o_loops_total)
    // A final position in transfer shows up as a final result next cycle.
    `BLN_ASSERT_NEXT(a_last_follows, i_clk, i_rst_n, in_accept && i_last_base, o_valid && o_last_out)
    // The input side only stalls while a result is held.
    `BLN_ASSERT_IMPL(a_stall_needs_result, i_clk, i_rst_n, o_stall, o_valid)

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

    import bln_pkg::*;

    localparam int STACK_DEPTH = STACK_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_BASES = 360;

    // One position of a structure, or a marker that holds the sender back.
    typedef struct {
        logic [PARTNER_W-1:0] partner;
        logic                 last;
        bit                   hold;
        bit                   calm;
    } t_base;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [PARTNER_W-1:0] i_partner;
    logic                 i_last_base;
    logic                 o_valid;
    logic                 i_stall;
    logic [LOOP_W-1:0]    o_loop_number;
    logic [LOOP_W-1:0]    o_loops_total;
    logic                 o_unbalanced;
    logic                 o_last_out;

    t_base   pending_bases[$];
    t_result expected_numbers[$];
    bit      fill_calm;
    bit      calm_mode;
    logic    took_base;
    int      cycles;
    int      fails;
    int      random_count;
    int      bases_sent;
    int      numbers_checked;
    int      structures_done;
    int      unbalanced_seen;

    // Predictor state for the structure being numbered.
    logic [PARTNER_W-1:0] pos_count;
    logic [LOOP_W-1:0]    loops_opened;
    logic [LOOP_W-1:0]    cur_loop;
    int                   open_depth;
    logic                 err_flag;
    logic [LOOP_W-1:0]    loop_stack [STACK_DEPTH];

    bracket_loop_numbering_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_partner     (i_partner),
        .i_last_base   (i_last_base),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_loop_number (o_loop_number),
        .o_loops_total (o_loops_total),
        .o_unbalanced  (o_unbalanced),
        .o_last_out    (o_last_out)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Per-structure state returns to its start; the stack contents are kept.
    function automatic void clear_structure();
        pos_count    = PARTNER_W'(1);
        loops_opened = '0;
        cur_loop     = '0;
        open_depth   = 0;
        err_flag     = 1'b0;
    endfunction

    // Loop number of one position, updating the predictor state.
    function automatic t_result number_position(logic [PARTNER_W-1:0] partner, logic last);
        t_result r;
        // An opening position counts a new loop and pushes it.
        if (partner != 0 && pos_count < partner) begin
            if (loops_opened < LOOP_MAX)
                loops_opened = loops_opened + 1'b1;
            cur_loop = loops_opened;
            if (open_depth < STACK_DEPTH) begin
                loop_stack[open_depth] = cur_loop;
                open_depth++;
            end else begin
                err_flag = 1'b1;
            end
        end
        r.loop_number = cur_loop;
        // A closing position returns to the enclosing loop.
        if (partner != 0 && pos_count > partner) begin
            if (open_depth == 0) begin
                err_flag = 1'b1;
                cur_loop = '0;
            end else begin
                open_depth--;
                cur_loop = (open_depth > 0) ? loop_stack[open_depth-1] : '0;
            end
        end
        r.loops_total = loops_opened;
        r.unbalanced  = err_flag;
        r.last_out    = last;
        if (pos_count < POS_MAX)
            pos_count = pos_count + 1'b1;
        if (last)
            clear_structure();
        return r;
    endfunction

    task automatic add_base(int partner, bit last);
        t_base b;
        b.partner = partner[PARTNER_W-1:0];
        b.last    = last;
        b.hold    = 1'b0;
        b.calm    = fill_calm;
        pending_bases.push_back(b);
    endtask

    task automatic add_hold();
        t_base b;
        b.partner = '0;
        b.last    = 1'b0;
        b.hold    = 1'b1;
        b.calm    = fill_calm;
        pending_bases.push_back(b);
    endtask

    // Random nested structure of n positions; a broken one gets a few bad
    // partners and may lose its final marker.
    task automatic add_structure(int n, bit broken);
        int pt[];
        int open_pos[$];
        int j;
        int choice;
        bit keep_last;
        pt = new[n+1];
        for (int i = 1; i <= n; i++) begin
            choice = $urandom_range(0, 2);
            if (open_pos.size() >= n - i + 1)
                choice = 1;
            else if (choice == 0 && open_pos.size() + 2 > n - i + 1)
                choice = 2;
            else if (choice == 1 && open_pos.size() == 0)
                choice = 2;
            if (choice == 0) begin
                open_pos.push_back(i);
                pt[i] = 0;
            end else if (choice == 1) begin
                j = open_pos.pop_back();
                pt[i] = j;
                pt[j] = i;
            end else begin
                pt[i] = 0;
            end
        end
        keep_last = 1'b1;
        if (broken) begin
            repeat ($urandom_range(1, 3))
                pt[$urandom_range(1, n)] = $urandom_range(0, n + 2);
            keep_last = $urandom_range(0, 1);
        end
        for (int i = 1; i <= n; i++)
            add_base(pt[i], keep_last && i == n);
        random_count += n;
    endtask

    // Reports one field that differs from its prediction.
    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fails++;
        end
    endtask

    // Sender: a new transfer is offered only once the last one has gone.
    always @(negedge i_clk) begin
        t_base nxt;
        logic  v;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || took_base) begin
            v = 1'b0;
            if (pending_bases.size() > 0 && pending_bases[0].hold) begin
                if (expected_numbers.size() == 0)
                    void'(pending_bases.pop_front());
            end else if (pending_bases.size() > 0) begin
                if (calm_mode || $urandom_range(0, 99) >= 30) begin
                    nxt = pending_bases.pop_front();
                    i_partner   <= nxt.partner;
                    i_last_base <= nxt.last;
                    calm_mode   <= nxt.calm;
                    v = 1'b1;
                end
            end
            i_valid <= v;
        end
    end

    // Receiver stalls at random outside the calm stretch.
    always @(negedge i_clk) begin
        if (!i_rst_n)
            i_stall <= 1'b0;
        else
            i_stall <= !calm_mode && $urandom_range(0, 99) < 30;
    end

    // Predict on each input transfer and check each output transfer.
    always @(posedge i_clk) begin
        t_result want;
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("bracket_loop_numbering_top test failed");
            $finish;
        end else if (!i_rst_n) begin
            clear_structure();
            took_base <= 1'b0;
        end else begin
            took_base <= i_valid && !o_stall;
            if (i_valid && !o_stall) begin
                expected_numbers.push_back(number_position(i_partner, i_last_base));
                bases_sent++;
            end
            if (o_valid && !i_stall) begin
                if (expected_numbers.size() == 0) begin
                    $error("result transfer with no position waiting");
                    fails++;
                end else begin
                    want = expected_numbers.pop_front();
                    check_field("loop_number", want.loop_number, o_loop_number);
                    check_field("loops_total", want.loops_total, o_loops_total);
                    check_field("unbalanced", want.unbalanced, o_unbalanced);
                    check_field("last_out", want.last_out, o_last_out);
                    numbers_checked++;
                    if (o_last_out)
                        structures_done++;
                    if (o_unbalanced)
                        unbalanced_seen++;
                end
            end
        end
    end

    initial begin
        int r;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_partner   = '0;
        i_last_base = 1'b0;
        i_stall     = 1'b0;
        took_base   = 1'b0;
        calm_mode   = 1'b0;
        fill_calm   = 1'b0;
        clear_structure();

        // Directed: unpaired, self-paired, close on empty, widest partners.
        add_base(0, 0);
        add_base(2, 0);
        add_base(1, 0);
        add_base(2047, 0);
        add_base(1024, 0);
        add_base(0, 0);
        add_base(5, 0);
        add_base(4, 1);
        // Small well-formed hairpin, then one-position structures.
        add_base(5, 0);
        add_base(4, 0);
        add_base(0, 0);
        add_base(2, 0);
        add_base(1, 1);
        add_base(0, 1);
        add_base(1, 1);
        add_base(1024, 1);
        add_hold();

        // One long structure: the stack fills and overflows, then a few closes
        // return to loops held deep in the stack.
        for (int i = 0; i < 515; i++)
            add_base(2047, 0);
        for (int i = 0; i < 4; i++)
            add_base(1, 0);
        add_base(1, 1);

        // Random part: mostly nested structures, some broken ones and noise.
        random_count = 0;
        while (random_count < RANDOM_BASES) begin
            fill_calm = random_count >= 120 && random_count < 240;
            if (random_count >= 280 && random_count < 300)
                add_hold();
            r = $urandom_range(0, 99);
            if (r < 70) begin
                add_structure(($urandom_range(0, 19) == 0) ? $urandom_range(41, 200)
                                                           : $urandom_range(1, 40), 1'b0);
            end else if (r < 85) begin
                add_structure($urandom_range(2, 40), 1'b1);
            end else begin
                repeat ($urandom_range(1, 10)) begin
                    add_base($urandom_range(0, 2047), $urandom_range(0, 9) == 0);
                    random_count++;
                end
            end
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: all positions sent and every loop number back.
        @(posedge i_clk);
        while (pending_bases.size() != 0 || i_valid || expected_numbers.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("Numbered %0d positions in %0d finished structures, %0d results checked,",
                 bases_sent, structures_done, numbers_checked);
        $display("with %0d results flagged unbalanced, including a stack overflow.",
                 unbalanced_seen);
        if (fails == 0 && expected_numbers.size() == 0)
            $display("bracket_loop_numbering_top test passed");
        else
            $display("bracket_loop_numbering_top test failed");
        $finish;
    end

endmodule
